// File: rtl/bmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the BMP stream decoder: payload structs,
// parser phases, result kinds, status codes and header layout.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // largest accepted width or height
  localparam int MaxDim    = 4096;
  localparam int DimW      = 13;
  localparam int IdxW      = 24;
  localparam int HdrCntW   = 6;

  // header layout
  localparam int HdrLen    = 54;
  localparam int OffWidth  = 18;
  localparam int OffHeight = 22;
  localparam int OffDepth  = 28;

  localparam logic [7:0] SigByte0  = 8'h42;  // 'B'
  localparam logic [7:0] SigByte1  = 8'h4D;  // 'M'
  localparam logic [7:0] Depth24   = 8'd24;
  localparam logic [7:0] Depth32   = 8'd32;
  localparam logic [7:0] AlphaFull = 8'd255;

  // component count that turns on the alpha channel
  localparam logic [2:0] CompRgba  = 3'd4;

  // result queue
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_PAD,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_BAD_SIG   = 3'd2,
    ST_BAD_DEPTH = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } bmp_in_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [IdxW-1:0]  pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DimW-1:0]  image_width;
    logic [DimW-1:0]  image_height;
    status_e          status_code;
    logic             last_result;
  } bmp_res_t;

  // results of one byte, handed from parser to queue
  typedef struct packed {
    logic [1:0] num;
    bmp_res_t   res0;
    bmp_res_t   res1;
  } bmp_push_t;

endpackage

// File: rtl/bmp_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_decoder_top
// Streaming BMP decoder: one file byte in per transfer, pixels and status out.
//
// Input channel in_valid_i/in_ready_o carries one file byte with start and
// end of file marks. Output channel out_valid_o/out_ready_i carries pixel,
// finished and error results, one per transfer.
// A byte is parsed in the cycle it is accepted; its results are written
// into the result queue. One byte is accepted every cycle while the queue
// has room; a byte may cause two results (last pixel plus finished or
// truncated status), which the four-entry result queue absorbs.
// The input is held off while fewer than two queue entries are free, so a
// stalled receiver stops input once three results wait in the queue;
// bytes that cause no result keep flowing until then. Nothing is lost.
// The configuration write (cfg_we_i, cfg_wdata_i) sets output_components;
// a value of 4 gives alpha 255 on every pixel.
// Reset empties the queue, returns the parser to waiting for a start of
// file byte and sets output_components to 4.
// ----------------------------------------------------------------------------
module bmp_stream_decoder_top import bmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bmp_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output bmp_res_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);

  logic [2:0] comp_q;
  logic       room;
  logic       in_accept;
  bmp_push_t  push;

  // output_components register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= CompRgba;
    end else if (cfg_we_i) begin
      comp_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = room;
  assign in_accept  = in_valid_i && room;

  bmp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .in_i       (in_data_i),
    .alpha_on_i (comp_q == CompRgba),
    .push_o     (push)
  );

  bmp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/bmp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_parser
// Header parser and pixel assembler. Consumes one accepted file byte per
// cycle while accept_i is high and produces up to two results for it.
// ----------------------------------------------------------------------------
module bmp_parser import bmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  bmp_in_t   in_i,
  input  logic      alpha_on_i,
  output bmp_push_t push_o
);

  phase_e               phase_q, phase_d;
  logic [HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [31:0]          width_q, width_d;
  logic [31:0]          height_q, height_d;
  logic                 depth32_q, depth32_d;
  logic                 sig_bad_q, sig_bad_d;
  logic                 depth_bad_q, depth_bad_d;
  logic [DimW-1:0]      col_q, col_d;
  logic [DimW-1:0]      row_q, row_d;
  logic [IdxW-1:0]      base_q, base_d;
  logic [1:0]           bip_q, bip_d;
  logic [7:0]           blue_q, blue_d;
  logic [7:0]           green_q, green_d;
  logic [1:0]           pad_q, pad_d;

  logic               sof, eof;
  logic [7:0]         b;
  phase_e             phase_eff;
  logic [HdrCntW-1:0] cnt_eff;
  logic [31:0]        wid_new, hgt_new;
  logic               sig_new, dep_bad_new, dep32_new;
  logic               hdr_last, hdr_err, zero_dim;
  status_e            hdr_status;
  logic [DimW-1:0]    row_init;
  logic [2*DimW-1:0]  base_prod;
  logic [DimW:0]      col_inc;
  logic               col_wrap, need_pad, row_last, consume_end, pad_end;
  logic               active, finished, pix_valid, tail_valid;
  bmp_res_t           pix_res, tail_res;

  assign sof = in_i.start_of_file;
  assign eof = in_i.end_of_file;
  assign b   = in_i.data_byte;

  // start of file restarts the header parse with this byte
  assign phase_eff = sof ? PH_HEADER : phase_q;
  assign cnt_eff   = sof ? '0 : hdr_cnt_q;

  // header field capture
  always_comb begin
    wid_new     = sof ? '0 : width_q;
    hgt_new     = sof ? '0 : height_q;
    sig_new     = sof ? 1'b0 : sig_bad_q;
    dep_bad_new = sof ? 1'b0 : depth_bad_q;
    dep32_new   = sof ? 1'b0 : depth32_q;
    if (cnt_eff == '0) begin
      sig_new = (b != SigByte0);
    end
    if (cnt_eff == HdrCntW'(1)) begin
      sig_new = sig_new || (b != SigByte1);
    end
    for (int k = 0; k < 4; k++) begin
      if (cnt_eff == HdrCntW'(OffWidth + k)) begin
        wid_new[8*k +: 8] = b;
      end
      if (cnt_eff == HdrCntW'(OffHeight + k)) begin
        hgt_new[8*k +: 8] = b;
      end
    end
    if (cnt_eff == HdrCntW'(OffDepth)) begin
      dep_bad_new = (b != Depth24) && (b != Depth32);
      dep32_new   = (b == Depth32);
    end
  end

  // header checks in priority order
  always_comb begin
    if (sig_new) begin
      hdr_status = ST_BAD_SIG;
    end else if (dep_bad_new) begin
      hdr_status = ST_BAD_DEPTH;
    end else if (wid_new > 32'(MaxDim) || hgt_new > 32'(MaxDim)) begin
      hdr_status = ST_TOO_LARGE;
    end else begin
      hdr_status = ST_OK;
    end
  end

  assign hdr_last  = (cnt_eff == HdrCntW'(HdrLen - 1));
  assign hdr_err   = (phase_eff == PH_HEADER) && hdr_last && (hdr_status != ST_OK);
  assign zero_dim  = (wid_new == '0) || (hgt_new == '0);
  // dimensions are checked before use, so the low bits hold them
  assign row_init  = hgt_new[DimW-1:0] - DimW'(1);
  assign base_prod = row_init * wid_new[DimW-1:0];

  // pixel walk conditions
  assign col_inc     = {1'b0, col_q} + (DimW+1)'(1);
  assign col_wrap    = (col_inc >= width_q[DimW:0]);
  assign need_pad    = !depth32_q && (width_q[1:0] != 2'd0);
  assign row_last    = (row_q == '0);
  assign consume_end = ((bip_q == 2'd2) && !depth32_q) || (bip_q == 2'd3);
  assign pad_end     = (pad_q <= 2'd1);

  assign active = (phase_eff == PH_HEADER) || (phase_eff == PH_PIXELS) ||
                  (phase_eff == PH_PAD);

  always_comb begin
    case (phase_eff)
      PH_HEADER: finished = hdr_last && (hdr_status == ST_OK) && zero_dim;
      PH_PIXELS: finished = consume_end && col_wrap && !need_pad && row_last;
      PH_PAD:    finished = pad_end && row_last;
      default:   finished = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    width_d     = width_q;
    height_d    = height_q;
    depth32_d   = depth32_q;
    sig_bad_d   = sig_bad_q;
    depth_bad_d = depth_bad_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    bip_d       = bip_q;
    blue_d      = blue_q;
    green_d     = green_q;
    pad_d       = pad_q;
    if (accept_i) begin
      case (phase_eff)
        PH_HEADER: begin
          phase_d     = PH_HEADER;
          width_d     = wid_new;
          height_d    = hgt_new;
          sig_bad_d   = sig_new;
          depth_bad_d = dep_bad_new;
          depth32_d   = dep32_new;
          hdr_cnt_d   = hdr_last ? cnt_eff : cnt_eff + HdrCntW'(1);
          if (hdr_last) begin
            if (hdr_status != ST_OK || zero_dim) begin
              phase_d = PH_DONE;
            end else begin
              row_d   = row_init;
              base_d  = base_prod[IdxW-1:0];
              col_d   = '0;
              bip_d   = 2'd0;
              phase_d = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          case (bip_q)
            2'd0: begin
              blue_d = b;
              bip_d  = 2'd1;
            end
            2'd1: begin
              green_d = b;
              bip_d   = 2'd2;
            end
            2'd2: bip_d = depth32_q ? 2'd3 : 2'd0;
            default: bip_d = 2'd0;
          endcase
          if (consume_end) begin
            if (!col_wrap) begin
              col_d = col_inc[DimW-1:0];
            end else begin
              col_d = '0;
              if (need_pad) begin
                pad_d   = width_q[1:0];
                phase_d = PH_PAD;
              end else if (row_last) begin
                phase_d = PH_DONE;
              end else begin
                row_d  = row_q - DimW'(1);
                base_d = base_q - width_q[IdxW-1:0];
              end
            end
          end
        end
        PH_PAD: begin
          if (pad_q != 2'd0) begin
            pad_d = pad_q - 2'd1;
          end
          if (pad_end) begin
            if (row_last) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_PIXELS;
              row_d   = row_q - DimW'(1);
              base_d  = base_q - width_q[IdxW-1:0];
            end
          end
        end
        default: ;
      endcase
      // end of file in an open image closes it
      if (active && (finished || eof)) begin
        phase_d = PH_DONE;
      end
    end
  end

  // result build
  always_comb begin
    pix_res              = '0;
    pix_res.result_kind  = KIND_PIXEL;
    pix_res.pixel_index  = base_q + IdxW'(col_q);
    pix_res.red          = b;
    pix_res.green        = green_q;
    pix_res.blue         = blue_q;
    pix_res.alpha        = alpha_on_i ? AlphaFull : 8'd0;
    pix_res.status_code  = ST_OK;

    tail_res             = '0;
    tail_res.last_result = 1'b1;
    if (hdr_err) begin
      tail_res.result_kind = KIND_ERROR;
      tail_res.status_code = hdr_status;
    end else if (finished) begin
      tail_res.result_kind  = KIND_DONE;
      tail_res.image_width  = wid_new[DimW-1:0];
      tail_res.image_height = hgt_new[DimW-1:0];
      tail_res.status_code  = ST_OK;
    end else begin
      tail_res.result_kind = KIND_ERROR;
      tail_res.status_code = ST_TRUNC;
    end
  end

  assign pix_valid  = (phase_eff == PH_PIXELS) && (bip_q == 2'd2);
  assign tail_valid = active && (hdr_err || finished || eof);

  // pack results for the queue
  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (pix_valid && tail_valid) begin
        push_o.num  = 2'd2;
        push_o.res0 = pix_res;
        push_o.res1 = tail_res;
      end else if (pix_valid) begin
        push_o.num              = 2'd1;
        push_o.res0             = pix_res;
        push_o.res0.last_result = 1'b1;
      end else if (tail_valid) begin
        push_o.num  = 2'd1;
        push_o.res0 = tail_res;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_cnt_q   <= '0;
      width_q     <= '0;
      height_q    <= '0;
      depth32_q   <= 1'b0;
      sig_bad_q   <= 1'b0;
      depth_bad_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      bip_q       <= 2'd0;
      pad_q       <= 2'd0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      width_q     <= width_d;
      height_q    <= height_d;
      depth32_q   <= depth32_d;
      sig_bad_q   <= sig_bad_d;
      depth_bad_q <= depth_bad_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      bip_q       <= bip_d;
      pad_q       <= pad_d;
    end
  end

  // held pixel channels
  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
  end

endmodule

// File: rtl/bmp_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_res_fifo
// Result queue. Takes up to two results per cycle from the parser and
// hands out one per transfer on the output channel.
// ----------------------------------------------------------------------------
module bmp_res_fifo import bmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bmp_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bmp_res_t  out_data_o
);

  bmp_res_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;
  logic [FifoPtrW-1:0]   wr_next;

  // room for the two results a byte can cause
  assign room_o      = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = wr_q + FifoPtrW'(1);

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q + FifoPtrW'(push_i.num);
    rd_d  = pop ? rd_q + FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q + FifoCntW'(push_i.num) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

endmodule
